/* rtl/core/ddl_lex_pkg.sv */
// Shared types and constants for the character lexer core.
// Holds the transfer payload structs, token class codes and character codes.
// No dependencies.
package ddl_lex_pkg;

  localparam int LINE_BITS = 20;
  localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
  localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

  // Results one input byte can cause, and queue depth that holds them
  localparam int MAX_RES = 3;
  localparam int Q_DEPTH = 4;

  // Token classes
  localparam logic [2:0] CLS_IDENT   = 3'd0;
  localparam logic [2:0] CLS_EQUALS  = 3'd1;
  localparam logic [2:0] CLS_COLON   = 3'd2;
  localparam logic [2:0] CLS_OPEN    = 3'd3;
  localparam logic [2:0] CLS_CLOSE   = 3'd4;
  localparam logic [2:0] CLS_LITERAL = 3'd5;
  localparam logic [2:0] CLS_INVALID = 3'd6;
  localparam logic [2:0] CLS_UNTERM  = 3'd7;

  // Character codes
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LBR   = 8'h7B;
  localparam logic [7:0] CH_RBR   = 8'h7D;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [7:0]           out_char;
    logic                 has_char;
    logic                 token_start;
    logic [2:0]           token_class;
    logic [LINE_BITS-1:0] start_line;
    logic                 last;
  } out_t;

  // Results of one byte, in order, with their count
  typedef struct packed {
    out_t [MAX_RES-1:0] item;
    logic [1:0]         count;
  } batch_t;

  function automatic out_t mk_res(input logic [7:0] c, input logic has,
                                  input logic start, input logic [2:0] cls,
                                  input logic [LINE_BITS-1:0] line);
    out_t r;
    r.out_char    = has ? c : CH_NUL;
    r.has_char    = has;
    r.token_start = start;
    r.token_class = cls;
    r.start_line  = line;
    r.last        = 1'b0;
    return r;
  endfunction

endpackage

/* rtl/core/ddl_lex_step.sv */
// Lexer state registers and the per-byte next-state and result logic.
// Produces up to three results for each transferred byte in one pass.
// Depends on ddl_lex_pkg.
module ddl_lex_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  ddl_lex_pkg::in_t   byte_in,
  output ddl_lex_pkg::batch_t batch
);

  typedef enum logic [6:0] {
    M_IDLE     = 7'b0000001,
    M_IDENT    = 7'b0000010,
    M_SLASH    = 7'b0000100,
    M_LCOMMENT = 7'b0001000,
    M_BCOMMENT = 7'b0010000,
    M_BSTAR    = 7'b0100000,
    M_LITERAL  = 7'b1000000
  } mode_t;

  mode_t                                mode, mode_next;
  logic [ddl_lex_pkg::LINE_BITS-1:0]    line_count, line_count_next;
  logic [ddl_lex_pkg::LINE_BITS-1:0]    token_line, token_line_next;
  logic [ddl_lex_pkg::LINE_BITS-1:0]    comment_line, comment_line_next;
  logic                                 prev_invalid, prev_invalid_next;
  logic                                 nl_pending, nl_pending_next;

  function automatic logic is_ident(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39) || c == ddl_lex_pkg::CH_UNDER ||
           c == ddl_lex_pkg::CH_DASH;
  endfunction

  // Walk one byte through the lexer, collecting results in order
  always_comb begin
    logic [7:0] c;
    logic       run_idle;
    logic [1:0] n;
    ddl_lex_pkg::out_t [ddl_lex_pkg::MAX_RES-1:0] res;

    c                  = byte_in.ch;
    run_idle           = 1'b0;
    n                  = 2'd0;
    res                = '0;
    mode_next          = mode;
    line_count_next    = line_count;
    token_line_next    = token_line;
    comment_line_next  = comment_line;
    prev_invalid_next  = prev_invalid;
    nl_pending_next    = nl_pending;

    unique case (mode)
      M_LITERAL: begin
        if (c == ddl_lex_pkg::CH_NL) begin
          if (line_count_next != ddl_lex_pkg::LINE_MAX) line_count_next = line_count_next + 1'b1;
          nl_pending_next = 1'b1;
          mode_next       = M_IDLE;
        end else begin
          res[n] = ddl_lex_pkg::mk_res(c, 1'b1, 1'b0, ddl_lex_pkg::CLS_LITERAL, token_line_next);
          n      = n + 2'd1;
        end
      end
      M_LCOMMENT: begin
        if (c == ddl_lex_pkg::CH_NL) begin
          if (line_count_next != ddl_lex_pkg::LINE_MAX) line_count_next = line_count_next + 1'b1;
          mode_next = M_IDLE;
        end
      end
      M_BCOMMENT: begin
        if (c == ddl_lex_pkg::CH_STAR) begin
          mode_next = M_BSTAR;
        end else if (c == ddl_lex_pkg::CH_NL) begin
          if (line_count_next != ddl_lex_pkg::LINE_MAX) line_count_next = line_count_next + 1'b1;
        end
      end
      M_BSTAR: begin
        if (c == ddl_lex_pkg::CH_SLASH) begin
          mode_next = M_IDLE;
        end else if (c != ddl_lex_pkg::CH_STAR) begin
          if (c == ddl_lex_pkg::CH_NL && line_count_next != ddl_lex_pkg::LINE_MAX) begin
            line_count_next = line_count_next + 1'b1;
          end
          mode_next = M_BCOMMENT;
        end
      end
      M_SLASH: begin
        if (c == ddl_lex_pkg::CH_SLASH) begin
          mode_next = M_LCOMMENT;
        end else if (c == ddl_lex_pkg::CH_STAR) begin
          comment_line_next = line_count_next;
          mode_next         = M_BCOMMENT;
        end else begin
          // Lone slash becomes an invalid token, then lex this byte afresh
          nl_pending_next   = 1'b0;
          prev_invalid_next = 1'b1;
          token_line_next   = line_count_next;
          res[n] = ddl_lex_pkg::mk_res(ddl_lex_pkg::CH_SLASH, 1'b1, 1'b1,
                                       ddl_lex_pkg::CLS_INVALID, token_line_next);
          n         = n + 2'd1;
          mode_next = M_IDLE;
          run_idle  = 1'b1;
        end
      end
      M_IDENT: begin
        if (is_ident(c)) begin
          res[n] = ddl_lex_pkg::mk_res(c, 1'b1, 1'b0, ddl_lex_pkg::CLS_IDENT, token_line_next);
          n      = n + 2'd1;
        end else begin
          mode_next = M_IDLE;
          run_idle  = 1'b1;
        end
      end
      default: begin
        mode_next = M_IDLE;
        run_idle  = 1'b1;
      end
    endcase

    // Start of token or skip
    if (run_idle) begin
      if (c == ddl_lex_pkg::CH_SPACE || c == ddl_lex_pkg::CH_TAB) begin
        // skip
      end else if (c == ddl_lex_pkg::CH_NL) begin
        if (line_count_next != ddl_lex_pkg::LINE_MAX) line_count_next = line_count_next + 1'b1;
      end else if (c == ddl_lex_pkg::CH_SLASH) begin
        mode_next = M_SLASH;
      end else if (c == ddl_lex_pkg::CH_COLON) begin
        if (nl_pending_next) begin
          // Merge into the previous literal, keeping its newline
          nl_pending_next = 1'b0;
          res[n] = ddl_lex_pkg::mk_res(ddl_lex_pkg::CH_NL, 1'b1, 1'b0,
                                       ddl_lex_pkg::CLS_LITERAL, token_line_next);
          n = n + 2'd1;
        end else begin
          prev_invalid_next = 1'b0;
          token_line_next   = line_count_next;
          res[n] = ddl_lex_pkg::mk_res(c, 1'b1, 1'b1, ddl_lex_pkg::CLS_COLON, token_line_next);
          n      = n + 2'd1;
          res[n] = ddl_lex_pkg::mk_res(ddl_lex_pkg::CH_NUL, 1'b0, 1'b1,
                                       ddl_lex_pkg::CLS_LITERAL, token_line_next);
          n      = n + 2'd1;
        end
        mode_next = M_LITERAL;
      end else if (c == ddl_lex_pkg::CH_EQ || c == ddl_lex_pkg::CH_LBR ||
                   c == ddl_lex_pkg::CH_RBR || is_ident(c)) begin
        nl_pending_next   = 1'b0;
        prev_invalid_next = 1'b0;
        token_line_next   = line_count_next;
        if (c == ddl_lex_pkg::CH_EQ) begin
          res[n] = ddl_lex_pkg::mk_res(c, 1'b1, 1'b1, ddl_lex_pkg::CLS_EQUALS, token_line_next);
        end else if (c == ddl_lex_pkg::CH_LBR) begin
          res[n] = ddl_lex_pkg::mk_res(c, 1'b1, 1'b1, ddl_lex_pkg::CLS_OPEN, token_line_next);
        end else if (c == ddl_lex_pkg::CH_RBR) begin
          res[n] = ddl_lex_pkg::mk_res(c, 1'b1, 1'b1, ddl_lex_pkg::CLS_CLOSE, token_line_next);
        end else begin
          res[n] = ddl_lex_pkg::mk_res(c, 1'b1, 1'b1, ddl_lex_pkg::CLS_IDENT, token_line_next);
          mode_next = M_IDENT;
        end
        n = n + 2'd1;
      end else begin
        // Invalid byte: extend an invalid run or open a new one
        nl_pending_next = 1'b0;
        if (prev_invalid_next) begin
          res[n] = ddl_lex_pkg::mk_res(c, 1'b1, 1'b0, ddl_lex_pkg::CLS_INVALID, token_line_next);
        end else begin
          prev_invalid_next = 1'b1;
          token_line_next   = line_count_next;
          res[n] = ddl_lex_pkg::mk_res(c, 1'b1, 1'b1, ddl_lex_pkg::CLS_INVALID, token_line_next);
        end
        n = n + 2'd1;
      end
    end

    // Close out the text: flush a pending slash or an open block comment
    if (byte_in.end_of_text) begin
      if (mode_next == M_SLASH) begin
        token_line_next = line_count_next;
        res[n] = ddl_lex_pkg::mk_res(ddl_lex_pkg::CH_SLASH, 1'b1, 1'b1,
                                     ddl_lex_pkg::CLS_INVALID, token_line_next);
        n = n + 2'd1;
      end else if (mode_next == M_BCOMMENT || mode_next == M_BSTAR) begin
        res[n] = ddl_lex_pkg::mk_res(ddl_lex_pkg::CH_SLASH, 1'b1, 1'b1,
                                     ddl_lex_pkg::CLS_UNTERM, comment_line_next);
        n = n + 2'd1;
        res[n] = ddl_lex_pkg::mk_res(ddl_lex_pkg::CH_STAR, 1'b1, 1'b0,
                                     ddl_lex_pkg::CLS_UNTERM, comment_line_next);
        n = n + 2'd1;
      end
      mode_next         = M_IDLE;
      line_count_next   = ddl_lex_pkg::LINE_ONE;
      token_line_next   = ddl_lex_pkg::LINE_ONE;
      comment_line_next = ddl_lex_pkg::LINE_ONE;
      prev_invalid_next = 1'b0;
      nl_pending_next   = 1'b0;
    end

    // Flag the final result of this byte
    if (n != 2'd0) res[n - 2'd1].last = 1'b1;

    batch.item  = res;
    batch.count = n;
  end

  // Advance the lexer state on each byte transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_IDLE;
      line_count   <= ddl_lex_pkg::LINE_ONE;
      token_line   <= ddl_lex_pkg::LINE_ONE;
      comment_line <= ddl_lex_pkg::LINE_ONE;
      prev_invalid <= 1'b0;
      nl_pending   <= 1'b0;
    end else if (take) begin
      mode         <= mode_next;
      line_count   <= line_count_next;
      token_line   <= token_line_next;
      comment_line <= comment_line_next;
      prev_invalid <= prev_invalid_next;
      nl_pending   <= nl_pending_next;
    end
  end

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    line_count != '0 && token_line != '0 && comment_line != '0)
    else $error("line counter left its legal range");

  a_pending_after_literal: assert property (@(posedge clk) disable iff (rst)
    nl_pending |-> (mode == M_IDLE || mode == M_SLASH || mode == M_LCOMMENT ||
                    mode == M_BCOMMENT || mode == M_BSTAR))
    else $error("literal newline pending while inside a token");

endmodule

/* rtl/core/ddl_lex_outq.sv */
// Four-entry result queue: takes up to three results a cycle while it has room, gives one while the receiver is ready.
// Decouples the lexer from a stalling receiver. Depends on ddl_lex_pkg.
module ddl_lex_outq (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ddl_lex_pkg::batch_t batch,
  output logic                room,
  output logic                valid,
  input  logic                ready,
  output ddl_lex_pkg::out_t   data
);

  ddl_lex_pkg::out_t q [ddl_lex_pkg::Q_DEPTH];
  logic [1:0] head;
  logic [2:0] count;
  logic [1:0] wr;
  logic [1:0] push_n;
  logic       pop;

  assign push_n = push ? batch.count : 2'd0;
  assign pop    = valid && ready;
  assign wr     = head + count[1:0];
  assign room   = count <= 3'd1;
  assign valid  = count != 3'd0;
  assign data   = q[head];

  // Write the new results behind the current tail
  always_ff @(posedge clk) begin
    for (int i = 0; i < ddl_lex_pkg::MAX_RES; i++) begin
      if (2'(i) < push_n) q[wr + 2'(i)] <= batch.item[i];
    end
  end

  // Advance the read side and the fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 2'd0;
      count <= 3'd0;
    end else begin
      if (pop) head <= head + 2'd1;
      count <= count + 3'(push_n) - 3'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push_n != 2'd0 |-> count <= 3'd1)
    else $error("results written into a queue without room");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (pop && push_n == 2'd0) |=> count == $past(count) - 3'd1)
    else $error("queue level lost track of a transfer");

endmodule

/* rtl/core/ddl_char_lexer_core.sv */
// Top level of the streaming character lexer.
// Instantiates ddl_lex_step and ddl_lex_outq; depends on ddl_lex_pkg.
//
// Usage:
//   src channel carries one text byte per transfer, with end_of_text set on
//   the final byte of a text. res channel carries token characters, one
//   result per transfer, with class, start line and a last flag marking the
//   final result caused by a byte. A byte may cause no result, or up to three.
//   A byte's results are registered in the result queue on its transfer and offered from there in order.
//   Throughput: one byte per cycle while each byte gives at most one result
//   and the receiver keeps up; the results of a byte that gives two or three
//   leave one per transfer. The four-entry result queue sets the figure:
//   src_ready is high while it holds at most one result.
//   Reset: lexer returns to idle on line 1, the queue empties.
//   Receiver stall: results stay queued and src_ready drops once the queue
//   holds two or more; nothing is lost or repeated.
//   After a byte with end_of_text the lexer starts afresh on line 1.
module ddl_char_lexer_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_ready,
  input  ddl_lex_pkg::in_t  src_data,
  output logic              res_valid,
  input  logic              res_ready,
  output ddl_lex_pkg::out_t res_data
);

  ddl_lex_pkg::batch_t batch;
  logic                take;

  // Byte transfer
  assign take = src_valid && src_ready;

  ddl_lex_step u_step (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .byte_in (src_data),
    .batch   (batch)
  );

  ddl_lex_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (take),
    .batch (batch),
    .room  (src_ready),
    .valid (res_valid),
    .ready (res_ready),
    .data  (res_data)
  );

endmodule
